### hw/rtl/lir_pkg.sv
// Shared types and constants for the linear interpolation resampler.
// Holds fixed-point widths, register indexes, state codes and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package lir_pkg;

    // Fixed-point position format and result budgets
    localparam int FRAC_BITS    = 16;
    localparam int MAX_UPSAMPLE = 4;
    localparam int MAX_RESULTS  = 8;

    // Field and register widths
    localparam int SMP_W  = 16;
    localparam int STEP_W = 21;
    localparam int LEN_W  = 16;
    localparam int CFG_W  = 21;

    // Derived widths
    localparam int POS_W  = LEN_W + FRAC_BITS + 1;
    localparam int LIM_W  = LEN_W + FRAC_BITS;
    localparam int IDX_W  = POS_W - FRAC_BITS;
    localparam int DIFF_W = SMP_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
    localparam int ACC_W  = PROD_W + 1;
    localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
    localparam int PH_W   = $clog2(MAX_UPSAMPLE + 1);

    // Smallest step honoured: ceil(one / MAX_UPSAMPLE)
    localparam longint MIN_STEP_L = ((64'd1 << FRAC_BITS) + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE;
    localparam logic [POS_W-1:0] MIN_STEP = POS_W'(MIN_STEP_L);

    // Reset values of the configuration registers
    localparam logic [STEP_W-1:0] RATE_STEP_RST    = STEP_W'(65536);
    localparam logic [LEN_W-1:0]  BLOCK_LENGTH_RST = LEN_W'(1600);

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_RATE_STEP    = 1'b0,
        CFG_BLOCK_LENGTH = 1'b1
    } t_cfg_idx;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_MULT  = 4'b0100,
        ST_LOOK  = 4'b1000
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic next_phase;
        logic mult;
        logic emit;
        logic finish;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic cond;
        logic closes;
        logic phase2;
        logic out_free;
        logic more;
    } t_sts;

endpackage

### hw/rtl/lir_ctrl.sv
// Sequencing state machine for the linear interpolation resampler.
// Issues load, phase, multiply, emit and finish commands to the datapath.
// Depends on lir_pkg.
`timescale 1ns / 1ps

module lir_ctrl
    import lir_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // Advance the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Decode next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // Refuse transfers while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.cond) begin
                    n_state = ST_MULT;
                end else if (!i_sts.phase2 && i_sts.closes) begin
                    o_cmd.next_phase = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = ST_LOOK;
            end
            ST_LOOK: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/lir_dp.sv
// Datapath of the linear interpolation resampler: configuration registers,
// source position, sample history, blend multiplier and output register.
// Depends on lir_pkg; driven by lir_ctrl commands.
`timescale 1ns / 1ps

module lir_dp
    import lir_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [0:0]              i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic signed [SMP_W-1:0] i_in_sample,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [SMP_W-1:0] o_out_sample,
    output logic                    o_run_last,
    output logic                    o_block_last
);

    logic [STEP_W-1:0]        r_rate_step;
    logic [LEN_W-1:0]         r_block_len;
    logic signed [SMP_W-1:0]  r_prev;
    logic signed [SMP_W-1:0]  r_x;
    logic [POS_W-1:0]         r_pos;
    logic [POS_W-1:0]         r_pos_nx;
    logic [LEN_W-1:0]         r_cnt;
    logic                     r_closes;
    logic                     r_phase2;
    logic [CNT_W-1:0]         r_count;
    logic [PH_W-1:0]          r_inph;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_out_valid;
    logic signed [SMP_W-1:0]  r_out_sample;
    logic                     r_run_last;
    logic                     r_block_last;

    logic [POS_W-1:0]         step_eff;
    logic [POS_W-1:0]         limit;
    logic [IDX_W-1:0]         idx_now;
    logic [IDX_W-1:0]         idx_nx;
    logic [IDX_W-1:0]         cnt_ext;
    logic                     idx_ok_now;
    logic                     idx_ok_nx;
    logic                     idx_ok_nx_p2;
    logic                     more_same;
    logic                     more_p2;
    logic signed [SMP_W-1:0]  first;
    logic signed [SMP_W-1:0]  second;
    logic signed [DIFF_W-1:0] diff;
    logic signed [FRAC_BITS:0] frac;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  adj;
    logic                     out_free;

    // Clamp the step to the upsampling floor
    always_comb begin
        step_eff = POS_W'(r_rate_step);
        if (step_eff < MIN_STEP) begin
            step_eff = MIN_STEP;
        end
    end

    assign limit   = POS_W'({r_block_len, {FRAC_BITS{1'b0}}});
    assign idx_now = r_pos[POS_W-1:FRAC_BITS];
    assign idx_nx  = r_pos_nx[POS_W-1:FRAC_BITS];
    assign cnt_ext = IDX_W'(r_cnt);

    // Index rule: before the current sample in the first phase, up to it at block end
    assign idx_ok_now   = r_phase2 ? (r_closes && idx_now <= cnt_ext) : (idx_now < cnt_ext);
    assign idx_ok_nx_p2 = r_closes && (idx_nx <= cnt_ext);
    assign idx_ok_nx    = r_phase2 ? idx_ok_nx_p2 : (idx_nx < cnt_ext);

    // Another result in this transfer: same phase, or the closing phase
    assign more_same = (r_count < CNT_W'(MAX_RESULTS - 1))
                     && (r_inph < PH_W'(MAX_UPSAMPLE - 1))
                     && (r_pos_nx < limit) && idx_ok_nx;
    assign more_p2   = !r_phase2 && (r_count < CNT_W'(MAX_RESULTS - 1))
                     && (r_pos_nx < limit) && idx_ok_nx_p2;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts          = '0;
        o_sts.cond     = (r_count < CNT_W'(MAX_RESULTS))
                       && (r_inph < PH_W'(MAX_UPSAMPLE))
                       && (r_pos < limit) && idx_ok_now;
        o_sts.closes   = r_closes;
        o_sts.phase2   = r_phase2;
        o_sts.out_free = out_free;
        o_sts.more     = more_same || more_p2;
    end

    // Blend operands: previous and current sample, or current held flat
    assign first  = r_phase2 ? r_x : r_prev;
    assign second = r_x;
    assign diff   = DIFF_W'(second) - DIFF_W'(first);
    assign frac   = $signed({1'b0, r_pos[FRAC_BITS-1:0]});

    // Sum and truncate toward zero
    assign acc = (ACC_W'(first) <<< FRAC_BITS) + ACC_W'(r_prod);
    assign adj = acc + (acc[ACC_W-1] ? ACC_W'((1 << FRAC_BITS) - 1) : ACC_W'(0));

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_step <= RATE_STEP_RST;
            r_block_len <= BLOCK_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RATE_STEP:    r_rate_step <= i_cfg_data[STEP_W-1:0];
                CFG_BLOCK_LENGTH: r_block_len <= i_cfg_data[LEN_W-1:0];
                default:          r_rate_step <= r_rate_step;
            endcase
        end
    end

    // Block state: history, position and sample count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_pos    <= '0;
            r_cnt    <= '0;
            r_closes <= 1'b0;
            r_phase2 <= 1'b0;
            r_count  <= '0;
            r_inph   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_closes <= (17'(r_cnt) + 17'd1) >= 17'(r_block_len);
                r_phase2 <= (r_cnt == '0);
                r_count  <= '0;
                r_inph   <= '0;
            end
            if (i_cmd.next_phase) begin
                r_phase2 <= 1'b1;
                r_inph   <= '0;
            end
            if (i_cmd.emit) begin
                r_pos   <= r_pos_nx;
                r_count <= r_count + CNT_W'(1);
                r_inph  <= r_inph + PH_W'(1);
            end
            if (i_cmd.finish) begin
                if (r_closes) begin
                    r_prev <= '0;
                    r_pos  <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_prev <= r_x;
                    r_cnt  <= r_cnt + LEN_W'(1);
                end
            end
        end
    end

    // Hold the sample, look one step ahead, register the product
    always_ff @(posedge i_clk) begin
        r_pos_nx <= r_pos + step_eff;
        if (i_cmd.load) begin
            r_x <= i_in_sample;
        end
        if (i_cmd.mult) begin
            r_prod <= PROD_W'(diff) * PROD_W'(frac);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_sample <= adj[FRAC_BITS+SMP_W-1:FRAC_BITS];
            r_run_last   <= !(more_same || more_p2);
            r_block_last <= (r_pos_nx >= limit);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_run_last   = r_run_last;
    assign o_block_last = r_block_last;

endmodule

### hw/rtl/linear_interp_resampler.sv
// Linear interpolation sample-rate converter, top level.
// Joins the lir_ctrl sequencer and the lir_dp datapath; depends on lir_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_sample) takes one signed
//   16-bit sample per transfer. Output channel (o_out_valid / i_out_ready)
//   returns zero or more interpolated samples per input, with o_run_last on
//   the last result of that input and o_block_last on the final one of a block.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 rate step unsigned Q5.16, 1 block length); write only while idle.
// Timing:
//   One input is processed at a time, giving at most 8 results. Each result
//   passes through the check, multiply and blend/emit steps of the shared
//   multiplier, and emit waits for a free output register. An input that
//   closes a block it did not open takes an extra check step to change to
//   the block-end hold. The first result follows the input transfer through
//   the check, multiply and emit states, after that phase change when only
//   the block-end hold of a closing sample produces results.
// Reset:
//   i_rst_n (synchronous, low) clears position, history and count and loads
//   rate step 65536, block length 1600; no input is taken while it is low.
// Stall:
//   A result waits in the output register; the next one is held in the
//   datapath until that register is taken, and no new input is taken meanwhile.
`timescale 1ns / 1ps

module linear_interp_resampler
    import lir_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [0:0]              i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [SMP_W-1:0] i_in_sample,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [SMP_W-1:0] o_out_sample,
    output logic                    o_run_last,
    output logic                    o_block_last
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    lir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath
    lir_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_sample  (i_in_sample),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_sample (o_out_sample),
        .o_run_last   (o_run_last),
        .o_block_last (o_block_last)
    );

    // Emit only into a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_out_valid || i_out_ready))
        else $error("result emitted over a pending output");

    // One input at a time: no new transfer right after one is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while previous one still in progress");

    // Run mark follows the look-ahead decision
    a_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> (o_out_valid && (o_run_last == !$past(sts.more))))
        else $error("run_last does not match look-ahead");

    // Finishing an input only happens with no result left to check
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> !sts.cond)
        else $error("finish issued while a result is still due");

endmodule

### test/tb_linear_interp_resampler.sv
// Self-checking testbench for linear_interp_resampler: drives samples through the
// valid/ready input, predicts every interpolated output and checks each transfer.
// Depends on lir_pkg and linear_interp_resampler.
`timescale 1ns / 1ps

module tb_linear_interp_resampler
    import lir_pkg::*;
();

    typedef longint unsigned t_u64;

    typedef struct {
        logic signed [SMP_W-1:0] sample;
        logic                    run_last;
        logic                    block_last;
    } t_interp_result;

    localparam t_u64 STEP_FLOOR    = ((64'd1 << FRAC_BITS) + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE;
    localparam t_u64 FRAC_MASK     = (64'd1 << FRAC_BITS) - 1;
    localparam int   SETTLE_CYCLES = 40;
    localparam int   HOLD_CYCLES   = 300;
    localparam int   QUIET_LIMIT   = 2000;
    localparam int   SAMPLE_TARGET = 460;

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_cfg_we     = 1'b0;
    logic [0:0]              i_cfg_index  = CFG_RATE_STEP;
    logic [CFG_W-1:0]        i_cfg_data   = '0;
    logic                    i_in_valid   = 1'b0;
    logic signed [SMP_W-1:0] i_in_sample  = '0;
    logic                    i_out_ready  = 1'b0;
    logic                    o_in_ready;
    logic                    o_out_valid;
    logic signed [SMP_W-1:0] o_out_sample;
    logic                    o_run_last;
    logic                    o_block_last;

    // Predicted converter state and register copies
    logic [STEP_W-1:0]       model_rate  = RATE_STEP_RST;
    logic [LEN_W-1:0]        model_len   = BLOCK_LENGTH_RST;
    logic signed [SMP_W-1:0] model_hist  = '0;
    t_u64                    model_pos   = 0;
    logic [LEN_W-1:0]        model_count = '0;

    t_interp_result pending_outputs[$];
    int             mismatches   = 0;
    int             samples_sent = 0;
    int             burst_left   = 0;
    bit             steady_sender = 1'b0;
    logic           hold_request = 1'b0;
    logic           hold_done    = 1'b0;
    int             hold_left    = 0;
    int             rx_tick      = 0;
    int             quiet_cycles = 0;

    always #2 i_clk = ~i_clk;

    linear_interp_resampler dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_sample  (i_in_sample),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_sample (o_out_sample),
        .o_run_last   (o_run_last),
        .o_block_last (o_block_last)
    );

    // Weighted mix of two samples, truncated toward zero
    function automatic logic signed [SMP_W-1:0] blend_pair(logic signed [SMP_W-1:0] a,
                                                          logic signed [SMP_W-1:0] b,
                                                          t_u64 frac);
        longint acc;
        longint mag;
        acc = (longint'(a) <<< FRAC_BITS) + (longint'(b) - longint'(a)) * longint'(frac);
        mag = (acc < 0) ? -acc : acc;
        mag = mag >>> FRAC_BITS;
        return SMP_W'((acc < 0) ? -mag : mag);
    endfunction

    // Work out the outputs one accepted sample releases and queue them
    function automatic void interpolate_sample(logic signed [SMP_W-1:0] x);
        t_u64                    adv;
        t_u64                    limit;
        t_u64                    max_idx;
        logic signed [SMP_W-1:0] first;
        t_interp_result          res[MAX_RESULTS];
        int                      count;
        int                      in_span;
        bit                      closes;
        adv = model_rate;
        if (adv < STEP_FLOOR) adv = STEP_FLOOR;
        limit = model_len;
        limit = limit << FRAC_BITS;
        closes = (t_u64'(model_count) + 1) >= t_u64'(model_len);
        count = 0;
        // Span 0 interpolates towards this sample, span 1 holds it at block end
        for (int span = 0; span < 2; span++) begin
            if ((span == 0) ? (model_count != 0) : closes) begin
                first = (span == 0) ? model_hist : x;
                max_idx = model_count;
                if (span == 0) max_idx = max_idx - 1;
                in_span = 0;
                while (count < MAX_RESULTS && in_span < MAX_UPSAMPLE && model_pos < limit
                       && (model_pos >> FRAC_BITS) <= max_idx) begin
                    res[count].sample = blend_pair(first, x, model_pos & FRAC_MASK);
                    res[count].run_last = 1'b0;
                    res[count].block_last = (model_pos + adv >= limit);
                    model_pos += adv;
                    count++;
                    in_span++;
                end
            end
        end
        for (int k = 0; k < count; k++) begin
            res[k].run_last = (k == count - 1);
            pending_outputs.push_back(res[k]);
        end
        if (closes) begin
            model_hist = '0;
            model_pos = 0;
            model_count = '0;
        end else begin
            model_hist = x;
            model_count = model_count + 1'b1;
        end
    endfunction

    function automatic logic signed [SMP_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return SMP_W'($urandom_range(0, 16) - 8);
            default: return SMP_W'($urandom());
        endcase
    endfunction

    // Offer one sample, in bursts with random gaps, and predict on transfer
    task automatic send_sample(logic signed [SMP_W-1:0] x);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_sample <= x;
        do @(posedge i_clk); while (!o_in_ready);
        interpolate_sample(x);
        samples_sent++;
    endtask

    // Stop sending and wait for every predicted output to be taken
    task automatic wait_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_outputs.size() != 0);
    endtask

    // Also let a sample that gives no output finish before touching registers
    task automatic drain();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_RATE_STEP)
            model_rate = value[STEP_W-1:0];
        else
            model_len = value[LEN_W-1:0];
    endtask

    // Default registers, field extremes, then a length cut below the count
    task automatic test_reset_values();
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        drain();
        write_reg(CFG_BLOCK_LENGTH, {5'h1F, 16'd3});
        send_sample(16'sd12345);
        drain();
    endtask

    // Steps below a quarter sample are raised, zero too; closing sample gives eight
    task automatic test_step_floor();
        write_reg(CFG_RATE_STEP, '0);
        write_reg(CFG_BLOCK_LENGTH, 16);
        write_reg(CFG_BLOCK_LENGTH, 4);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        drain();
        write_reg(CFG_RATE_STEP, 100);
        write_reg(CFG_BLOCK_LENGTH, 2);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        drain();
    endtask

    // Zero length closes on every sample with no output; length one gives one each
    task automatic test_short_blocks();
        write_reg(CFG_RATE_STEP, 65536);
        write_reg(CFG_BLOCK_LENGTH, 0);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        drain();
        write_reg(CFG_BLOCK_LENGTH, 1);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        drain();
    endtask

    // Fractional positions across full-scale swings, then a step of 16 samples
    task automatic test_fractions();
        write_reg(CFG_RATE_STEP, 21'h0C000);
        write_reg(CFG_BLOCK_LENGTH, 3);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        drain();
        write_reg(CFG_RATE_STEP, 1048576);
        write_reg(CFG_BLOCK_LENGTH, 2);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        drain();
    endtask

    // Longest block, with the sender paused mid-block until all outputs are in
    task automatic test_mid_block_pause();
        write_reg(CFG_RATE_STEP, CFG_W'($urandom_range(16384, 131072)));
        write_reg(CFG_BLOCK_LENGTH, 65535);
        repeat (6) send_sample(random_sample());
        wait_results();
        repeat (6) send_sample(random_sample());
        drain();
    endtask

    // Hold the output off for a long stretch while samples keep coming
    task automatic test_output_backpressure();
        write_reg(CFG_RATE_STEP, 16384);
        write_reg(CFG_BLOCK_LENGTH, 12);
        steady_sender = 1'b1;
        hold_request <= 1'b1;
        repeat (24) send_sample(random_sample());
        hold_request <= 1'b0;
        steady_sender = 1'b0;
        drain();
    endtask

    // Random rates and lengths, mostly whole blocks with some cut short
    task automatic test_random_blocks();
        logic [CFG_W-1:0] rate;
        logic [CFG_W-1:0] len;
        int               items;
        while (samples_sent < SAMPLE_TARGET) begin
            case ($urandom_range(0, 5))
                0: rate = 16384;
                1: rate = 1048576;
                2: rate = 65536;
                3: rate = CFG_W'($urandom_range(16384, 1048576));
                default: rate = CFG_W'($urandom_range(16384, 131072));
            endcase
            case ($urandom_range(0, 6))
                0: len = 1;
                1: len = 65535;
                2: len = CFG_W'($urandom_range(9, 24));
                default: len = CFG_W'($urandom_range(2, 8));
            endcase
            write_reg(CFG_RATE_STEP, rate);
            write_reg(CFG_BLOCK_LENGTH, len);
            if (len == 65535) begin
                items = $urandom_range(4, 16);
            end else begin
                items = int'(len) * $urandom_range(1, 4);
                if ($urandom_range(0, 2) == 0) items += $urandom_range(0, int'(len) - 1);
            end
            // Stop close to the target count
            if (items > SAMPLE_TARGET - samples_sent) items = SAMPLE_TARGET - samples_sent;
            repeat (items) send_sample(random_sample());
            drain();
        end
    endtask

    // Output ready: free, random and patterned stretches, plus one long hold
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_tick[8:7])
                2'd0: i_out_ready <= 1'b1;
                2'd1: i_out_ready <= ($urandom_range(0, 3) != 0);
                2'd2: i_out_ready <= (rx_tick[2:0] < 3'd5);
                default: i_out_ready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    // Compare each output transfer with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_interp_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_outputs.size() == 0) begin
                $error("unexpected output: out_sample %0d run_last %0b block_last %0b",
                       o_out_sample, o_run_last, o_block_last);
                mismatches++;
            end else begin
                want = pending_outputs.pop_front();
                if (o_out_sample !== want.sample) begin
                    $error("out_sample: expected %0d, got %0d", want.sample, o_out_sample);
                    mismatches++;
                end
                if (o_run_last !== want.run_last) begin
                    $error("run_last: expected %0b, got %0b", want.run_last, o_run_last);
                    mismatches++;
                end
                if (o_block_last !== want.block_last) begin
                    $error("block_last: expected %0b, got %0b", want.block_last, o_block_last);
                    mismatches++;
                end
            end
        end
    end

    // Abort when no transfer happens on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("linear_interp_resampler test failed");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_step_floor();
        test_short_blocks();
        test_fractions();
        test_mid_block_pause();
        test_output_backpressure();
        test_random_blocks();
        if (pending_outputs.size() != 0)
            $error("%0d predicted outputs never arrived", pending_outputs.size());
        if (mismatches == 0 && pending_outputs.size() == 0)
            $display("linear_interp_resampler test passed");
        else
            $display("linear_interp_resampler test failed");
        $finish;
    end

endmodule
